>>> design/sorted_table_insert_remove_search_assert.svh
// assertion macros of the sorted table design
`ifndef SORTED_TABLE_INSERT_REMOVE_SEARCH_ASSERT_SVH
`define SORTED_TABLE_INSERT_REMOVE_SEARCH_ASSERT_SVH

// same-cycle implication
`define STRIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted table assertion failed");

// next-cycle implication
`define STRIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted table assertion failed");

`endif

>>> design/stris_pkg.sv
// types and constants of the sorted table
`timescale 1ns / 1ps

package stris_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_RANGE     = 2'd3
	} status_t;

endpackage

>>> design/stris_req_if.sv
// request channel of the sorted table
`timescale 1ns / 1ps

interface stris_req_if;
	logic                                 valid;
	logic                                 ready;
	stris_pkg::req_t                      req_type;
	logic signed [stris_pkg::VALUE_W-1:0] value;
	logic [stris_pkg::INDEX_W-1:0]        index;

	modport source(output valid, req_type, value, index, input ready);
	modport sink(input valid, req_type, value, index, output ready);
endinterface

>>> design/stris_rsp_if.sv
// result channel of the sorted table
`timescale 1ns / 1ps

interface stris_rsp_if;
	logic                                 valid;
	logic                                 ready;
	stris_pkg::status_t                   status;
	logic [stris_pkg::POS_W-1:0]          position;
	logic signed [stris_pkg::VALUE_W-1:0] data;
	logic [stris_pkg::COUNT_W-1:0]        count;

	modport source(output valid, status, position, data, count, input ready);
	modport sink(input valid, status, position, data, count, output ready);
endinterface

>>> design/stris_ram.sv
// entry memory of the sorted table, one write and one registered read port
`timescale 1ns / 1ps

module stris_ram #(
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [$clog2(DEPTH)-1:0]             wr_addr,
	input  logic signed [stris_pkg::VALUE_W-1:0] wr_data,
	input  logic                                 rd_en,
	input  logic [$clog2(DEPTH)-1:0]             rd_addr,
	output logic signed [stris_pkg::VALUE_W-1:0] rd_data
);

	logic signed [stris_pkg::VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/sorted_table_insert_remove_search.sv
// Sorted table of signed 32-bit words held in ascending order in one memory with a single
// read and a single write port. An insert reads the entries from the top down until it finds
// its place, and a remove reads every entry held (one memory read per entry, the shift written
// back behind it). A search is a binary search with a read state and a compare state per
// probe, and a read fetches the one entry asked for.
// The single memory read port sets the pace of every request. One request is worked at a time; the next
// is taken as soon as the result sits in the output register, even if it is not yet taken.
// Equal values are inserted after those already held; remove takes the first equal entry.
`timescale 1ns / 1ps

`include "sorted_table_insert_remove_search_assert.svh"

module sorted_table_insert_remove_search #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	stris_req_if.sink   req,
	stris_rsp_if.source rsp
);

	localparam int PW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int VALUE_W = stris_pkg::VALUE_W;
	localparam int POS_W   = stris_pkg::POS_W;
	localparam int COUNT_W = stris_pkg::COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_REM,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_RD,
		ST_FIN
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             ptr_q;
	logic signed [VALUE_W-1:0] val_q;
	logic                      found_q;
	logic [PW-1:0]             pos_q;
	logic signed [VALUE_W-1:0] data_q;
	stris_pkg::status_t        status_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hx_q;
	logic [PW-1:0]             mid_q;
	logic                      rd_valid_s1;
	logic [CW-1:0]             rd_k_s1;

	logic                      rsp_valid_q;
	stris_pkg::status_t        rsp_status_q;
	logic [POS_W-1:0]          rsp_pos_q;
	logic signed [VALUE_W-1:0] rsp_data_q;
	logic [COUNT_W-1:0]        rsp_count_q;

	logic                      rd_en;
	logic [PW-1:0]             rd_addr;
	logic signed [VALUE_W-1:0] rd_data;
	logic                      wr_en;
	logic [PW-1:0]             wr_addr;
	logic signed [VALUE_W-1:0] wr_data;

	logic                      accept;
	logic                      ins_place;
	logic                      ins_issue;
	logic                      rem_issue;
	logic                      rem_done;
	logic [CW:0]               mid_sum;
	logic [PW-1:0]             mid;
	logic [CW-1:0]             lo_nx;
	logic [CW-1:0]             hx_nx;
	logic                      range_err;

	assign req.ready    = (state_q == ST_IDLE);
	assign accept       = req.valid && req.ready;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.position = rsp_pos_q;
	assign rsp.data     = rsp_data_q;
	assign rsp.count    = rsp_count_q;

	assign range_err = 32'(req.index) >= 32'(cnt_q);

	// insert walks down from the top, remove walks up from the bottom
	assign ins_place = (state_q == ST_INS) &&
		((rd_valid_s1 && !(rd_data > val_q)) || (!rd_valid_s1 && ptr_q == '0));
	assign ins_issue = (state_q == ST_INS) && (ptr_q != '0) && !ins_place;
	assign rem_issue = (state_q == ST_REM) && (ptr_q != cnt_q);
	assign rem_done  = (state_q == ST_REM) && !rd_valid_s1 && (ptr_q == cnt_q);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CW + 1)'(1);
	assign mid     = PW'(mid_sum >> 1);
	assign lo_nx   = CW'(mid_q) + CW'(1);
	assign hx_nx   = CW'(mid_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept && (req.req_type == stris_pkg::REQ_READ);
				rd_addr = PW'(req.index);
			end
			ST_INS: begin
				rd_en   = ins_issue;
				rd_addr = PW'(ptr_q - CW'(1));
				wr_en   = rd_valid_s1 || ins_place;
				wr_addr = (rd_valid_s1) ? PW'(rd_k_s1) : '0;
				wr_data = (ins_place) ? val_q : rd_data;
			end
			ST_REM: begin
				rd_en   = rem_issue;
				rd_addr = PW'(ptr_q);
				wr_en   = rd_valid_s1 && found_q;
				wr_addr = PW'(rd_k_s1 - CW'(1));
			end
			ST_SRCH_RD: begin
				rd_en   = 1'b1;
				rd_addr = mid;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	stris_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= ins_issue || rem_issue;
			rd_k_s1     <= ptr_q;
			if (rsp_valid_q && rsp.ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						val_q   <= req.value;
						found_q <= 1'b0;
						pos_q   <= (req.req_type == stris_pkg::REQ_READ && !range_err) ?
							PW'(req.index) : '0;
						data_q  <= '0;
						case (req.req_type)
							stris_pkg::REQ_INSERT: begin
								if (cnt_q == CW'(DEPTH)) begin
									status_q <= stris_pkg::STATUS_FULL;
									state_q  <= ST_FIN;
								end else begin
									status_q <= stris_pkg::STATUS_OK;
									ptr_q    <= cnt_q;
									state_q  <= ST_INS;
								end
							end
							stris_pkg::REQ_REMOVE: begin
								if (cnt_q == '0) begin
									status_q <= stris_pkg::STATUS_NOT_FOUND;
									state_q  <= ST_FIN;
								end else begin
									status_q <= stris_pkg::STATUS_OK;
									ptr_q    <= '0;
									state_q  <= ST_REM;
								end
							end
							stris_pkg::REQ_SEARCH: begin
								if (cnt_q == '0) begin
									status_q <= stris_pkg::STATUS_NOT_FOUND;
									state_q  <= ST_FIN;
								end else begin
									status_q <= stris_pkg::STATUS_OK;
									lo_q     <= '0;
									hx_q     <= cnt_q;
									state_q  <= ST_SRCH_RD;
								end
							end
							stris_pkg::REQ_READ: begin
								if (range_err) begin
									status_q <= stris_pkg::STATUS_RANGE;
									state_q  <= ST_FIN;
								end else begin
									status_q <= stris_pkg::STATUS_OK;
									state_q  <= ST_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INS: begin
					if (ins_issue) begin
						ptr_q <= ptr_q - CW'(1);
					end
					if (ins_place) begin
						pos_q   <= (rd_valid_s1) ? PW'(rd_k_s1) : '0;
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_REM: begin
					if (rem_issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (rd_valid_s1 && !found_q && rd_data == val_q) begin
						found_q <= 1'b1;
						pos_q   <= PW'(rd_k_s1);
					end
					if (rem_done) begin
						if (found_q) begin
							cnt_q <= cnt_q - CW'(1);
						end else begin
							status_q <= stris_pkg::STATUS_NOT_FOUND;
						end
						state_q <= ST_FIN;
					end
				end
				ST_SRCH_RD: begin
					mid_q   <= mid;
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					if (rd_data == val_q) begin
						pos_q   <= mid_q;
						data_q  <= rd_data;
						state_q <= ST_FIN;
					end else if (rd_data < val_q) begin
						lo_q <= lo_nx;
						if (lo_nx >= hx_q) begin
							status_q <= stris_pkg::STATUS_NOT_FOUND;
							state_q  <= ST_FIN;
						end else begin
							state_q <= ST_SRCH_RD;
						end
					end else begin
						hx_q <= hx_nx;
						if (lo_q >= hx_nx) begin
							status_q <= stris_pkg::STATUS_NOT_FOUND;
							state_q  <= ST_FIN;
						end else begin
							state_q <= ST_SRCH_RD;
						end
					end
				end
				ST_RD: begin
					data_q  <= rd_data;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_pos_q    <= POS_W'(pos_q);
						rsp_data_q   <= data_q;
						rsp_count_q  <= COUNT_W'(cnt_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`STRIS_ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`STRIS_ASSERT_IMPL(a_write_busy, clk, arst_n, wr_en, state_q == ST_INS || state_q == ST_REM)
	`STRIS_ASSERT_IMPL(a_search_bounds, clk, arst_n, state_q == ST_SRCH_RD, lo_q < hx_q)
	`STRIS_ASSERT_NEXT(a_count_hold, clk, arst_n, state_q != ST_INS && state_q != ST_REM, cnt_q == $past(cnt_q))

endmodule

>>> dv/sorted_table_scoreboard.sv
// scoreboard that predicts the sorted table and checks every result word
`timescale 1ns / 1ps

module sorted_table_scoreboard #(
	parameter int DEPTH = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	stris_req_if  req,
	stris_rsp_if  rsp,
	output int    failures,
	output int    pending
);

	typedef struct {
		stris_pkg::status_t                     status;
		logic [stris_pkg::POS_W-1:0]            position;
		logic signed [stris_pkg::VALUE_W-1:0]   data;
		logic [stris_pkg::COUNT_W-1:0]          count;
	} table_answer_t;

	logic signed [stris_pkg::VALUE_W-1:0] words [DEPTH];
	int                                   held;
	int                                   mismatches;
	table_answer_t                        answers [$];

	function automatic table_answer_t apply_to_table(stris_pkg::req_t kind,
			logic signed [stris_pkg::VALUE_W-1:0] v, logic [stris_pkg::INDEX_W-1:0] idx);
		table_answer_t a;
		int            slot;
		int            k;
		int            lo;
		int            hi;
		int            mid;
		a.status   = stris_pkg::STATUS_OK;
		a.position = '0;
		a.data     = '0;
		case (kind)
			stris_pkg::REQ_INSERT: begin
				if (held >= DEPTH) begin
					a.status = stris_pkg::STATUS_FULL;
				end else begin
					slot = 0;
					while (slot < held && words[slot] <= v)
						slot++;
					for (k = held; k > slot; k--)
						words[k] = words[k - 1];
					words[slot] = v;
					held++;
					a.position = stris_pkg::POS_W'(slot);
				end
			end
			stris_pkg::REQ_REMOVE: begin
				slot = 0;
				while (slot < held && words[slot] != v)
					slot++;
				if (slot >= held) begin
					a.status = stris_pkg::STATUS_NOT_FOUND;
				end else begin
					for (k = slot; k + 1 < held; k++)
						words[k] = words[k + 1];
					held--;
					a.position = stris_pkg::POS_W'(slot);
				end
			end
			stris_pkg::REQ_SEARCH: begin
				a.status = stris_pkg::STATUS_NOT_FOUND;
				lo = 0;
				hi = held - 1;
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if (words[mid] == v) begin
						a.status   = stris_pkg::STATUS_OK;
						a.position = stris_pkg::POS_W'(mid);
						a.data     = words[mid];
						break;
					end
					if (words[mid] < v)
						lo = mid + 1;
					else
						hi = mid - 1;
				end
			end
			default: begin
				if (idx >= held) begin
					a.status = stris_pkg::STATUS_RANGE;
				end else begin
					a.position = idx;
					a.data     = words[idx];
				end
			end
		endcase
		a.count = stris_pkg::COUNT_W'(held);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_answer_t want;
		if (!arst_n) begin
			held = 0;
			mismatches = 0;
			answers.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					$error("result word with no request waiting");
					mismatches++;
				end else begin
					want = answers.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, rsp.position);
						mismatches++;
					end
					if (rsp.data !== want.data) begin
						$error("data: expected %0d, got %0d", want.data, rsp.data);
						mismatches++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				answers.push_back(apply_to_table(req.req_type, req.value, req.index));
			failures <= mismatches;
			pending <= answers.size();
		end
	end

endmodule

>>> dv/sorted_table_insert_remove_search_test.sv
// top of the sorted table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module sorted_table_insert_remove_search_test;

	localparam int DEPTH = 64;
	localparam int LIMIT = 400000;
	localparam int RANDOM_WORDS = 450;
	localparam logic signed [stris_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [stris_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_t;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   cycle_count = 0;
	int   burst_left = 1;

	stris_req_if req_ch();
	stris_rsp_if rsp_ch();

	sorted_table_insert_remove_search #(
		.DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	sorted_table_scoreboard #(
		.DEPTH(DEPTH)
	) table_scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.failures(failures),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic offer(input stris_pkg::req_t kind,
			input logic signed [stris_pkg::VALUE_W-1:0] v,
			input logic [stris_pkg::INDEX_W-1:0] idx);
		int gap;
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.value    <= v;
		req_ch.index    <= idx;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic signed [stris_pkg::VALUE_W-1:0] pick_value(
			logic signed [stris_pkg::VALUE_W-1:0] base);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return base + stris_pkg::VALUE_W'($urandom_range(0, 7));
		if (r < 75) begin
			case ($urandom_range(0, 5))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				2: return VALUE_MIN + 1;
				3: return VALUE_MAX - 1;
				4: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic stris_pkg::req_t pick_kind(phase_t phase);
		int r;
		r = $urandom_range(0, 99);
		case (phase)
			PHASE_FILL:
				return (r < 80) ? stris_pkg::REQ_INSERT : (r < 88) ? stris_pkg::REQ_REMOVE :
					(r < 95) ? stris_pkg::REQ_SEARCH : stris_pkg::REQ_READ;
			PHASE_DRAIN:
				return (r < 10) ? stris_pkg::REQ_INSERT : (r < 75) ? stris_pkg::REQ_REMOVE :
					(r < 88) ? stris_pkg::REQ_SEARCH : stris_pkg::REQ_READ;
			default:
				return (r < 30) ? stris_pkg::REQ_INSERT : (r < 55) ? stris_pkg::REQ_REMOVE :
					(r < 80) ? stris_pkg::REQ_SEARCH : stris_pkg::REQ_READ;
		endcase
	endfunction

	// receiver: changing stall patterns, one long hold to back the block up
	initial begin
		int  tick;
		int  seg;
		int  mode;
		bit  held_off;
		tick = 0;
		held_off = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			seg = $urandom_range(16, 160);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				tick++;
				if (!held_off && tick >= 1500 && req_ch.valid) begin
					rsp_ch.ready <= 1'b0;
					repeat (400) @(posedge clk);
					held_off = 1'b1;
				end
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= (tick % 4 == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		phase_t                               phase;
		logic signed [stris_pkg::VALUE_W-1:0] base;
		logic [stris_pkg::INDEX_W-1:0]        idx;
		stris_pkg::req_t                      kind;
		int                                   words_sent;
		int                                   phase_len;
		arst_n = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= stris_pkg::REQ_INSERT;
		req_ch.value    <= '0;
		req_ch.index    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		offer(stris_pkg::REQ_READ, '0, '0);
		offer(stris_pkg::REQ_SEARCH, '0, '0);
		offer(stris_pkg::REQ_REMOVE, '0, '0);
		// extremes and equal values
		offer(stris_pkg::REQ_INSERT, '0, '0);
		offer(stris_pkg::REQ_INSERT, VALUE_MIN, '0);
		offer(stris_pkg::REQ_INSERT, VALUE_MAX, '0);
		offer(stris_pkg::REQ_INSERT, '0, '1);
		offer(stris_pkg::REQ_INSERT, -1, '0);
		offer(stris_pkg::REQ_INSERT, '0, '0);
		offer(stris_pkg::REQ_SEARCH, '0, '0);
		offer(stris_pkg::REQ_SEARCH, VALUE_MIN, '0);
		offer(stris_pkg::REQ_SEARCH, VALUE_MAX, '0);
		offer(stris_pkg::REQ_SEARCH, 5, '0);
		offer(stris_pkg::REQ_READ, '0, '0);
		offer(stris_pkg::REQ_READ, '0, 6'd5);
		offer(stris_pkg::REQ_READ, '0, 6'd6);
		offer(stris_pkg::REQ_READ, '1, '1);
		offer(stris_pkg::REQ_REMOVE, '0, '0);
		offer(stris_pkg::REQ_REMOVE, 7, '0);
		offer(stris_pkg::REQ_REMOVE, VALUE_MIN, '0);
		offer(stris_pkg::REQ_REMOVE, VALUE_MAX, '0);
		offer(stris_pkg::REQ_SEARCH, -1, '0);
		settle();

		// first phase fills the table past full
		words_sent = 0;
		phase = PHASE_FILL;
		phase_len = 100;
		base = $urandom;
		while (words_sent < RANDOM_WORDS) begin
			if (phase_len > RANDOM_WORDS - words_sent)
				phase_len = RANDOM_WORDS - words_sent;
			repeat (phase_len) begin
				kind = pick_kind(phase);
				idx = ($urandom_range(0, 1) == 0) ? stris_pkg::INDEX_W'($urandom_range(0, 15)) :
					stris_pkg::INDEX_W'($urandom_range(0, 63));
				offer(kind, pick_value(base), idx);
				words_sent++;
			end
			if ($urandom_range(0, 2) == 0)
				settle();
			case ($urandom_range(0, 2))
				0: begin
					phase = PHASE_FILL;
					case ($urandom_range(0, 3))
						0: base = VALUE_MAX - 3;
						1: base = VALUE_MIN;
						default: base = $urandom;
					endcase
				end
				1: phase = PHASE_DRAIN;
				default: phase = PHASE_MIX;
			endcase
			phase_len = (phase == PHASE_FILL) ? $urandom_range(60, 100) : $urandom_range(30, 90);
		end

		settle();
		repeat (DEPTH + 8) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
